### rtl/sir_pkg.sv
// Shared constants and types for the sparse index reshape block.
package sir_pkg;
    localparam int MAX_RANK_DEF = 4;
    localparam int CRD_W = 32;
    localparam int IDX_W = 64;
    typedef logic [CRD_W-1:0] t_crd;
    typedef logic [IDX_W-1:0] t_idx;
endpackage

### rtl/sir_divmod.sv
// Bit-serial pipelined 64 by 33 bit divider, one quotient bit per stage, with side data.
module sir_divmod #(
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sir_pkg::t_idx        i_dividend,
    input  logic [sir_pkg::CRD_W:0] i_divisor,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output sir_pkg::t_idx        o_quot,
    output sir_pkg::t_crd        o_rem,
    output logic [SW-1:0]        o_side
);
    import sir_pkg::*;

    localparam int NST = IDX_W;

    logic          r_val  [NST+1];
    t_idx          r_q    [NST+1];
    t_crd          r_r    [NST+1];
    logic [SW-1:0] r_side [NST+1];

    assign r_val[0]  = i_valid;
    assign r_q[0]    = i_dividend;
    assign r_r[0]    = '0;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic [CRD_W:0] n_t;
        logic           n_ge;
        logic [CRD_W:0] n_d;
        always_comb begin
            n_t  = {r_r[k], r_q[k][IDX_W-1]};
            n_ge = (n_t >= i_divisor);
            n_d  = n_ge ? (n_t - i_divisor) : n_t;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else if (i_en) begin
                r_val[k+1] <= r_val[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k+1]    <= n_d[CRD_W-1:0];
                r_q[k+1]    <= {r_q[k][IDX_W-2:0], n_ge};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_val[NST];
    assign o_quot  = r_q[NST];
    assign o_rem   = r_r[NST];
    assign o_side  = r_side[NST];
endmodule

### rtl/sparse_index_reshape.sv
// Top level: flattens a coordinate tuple to a linear index and splits it under a new shape.
// Pipeline: an input register and the flatten stages, followed by the 64 one-bit divider
// stages per output dimension.
// Throughput: one item per cycle; a single enable stalls the whole pipeline while a
// result waits at the output.
// Reset: synchronous active low; clears valid bits and sets all dimension sizes to 1.
// Configuration is taken every cycle and must only change while the pipeline is empty.
module sparse_index_reshape #(
    parameter int MAX_RANK = sir_pkg::MAX_RANK_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [$clog2(2*MAX_RANK):0]       i_cfg_index,
    input  sir_pkg::t_crd                     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sir_pkg::t_crd                     i_in_coord_0,
    input  sir_pkg::t_crd                     i_in_coord_1,
    input  sir_pkg::t_crd                     i_in_coord_2,
    input  sir_pkg::t_crd                     i_in_coord_3,
    input  logic                              i_is_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sir_pkg::t_crd                     o_out_coord_0,
    output sir_pkg::t_crd                     o_out_coord_1,
    output sir_pkg::t_crd                     o_out_coord_2,
    output sir_pkg::t_crd                     o_out_coord_3,
    output logic                              o_last_out
);
    import sir_pkg::*;

    localparam int R   = MAX_RANK;
    localparam int NS  = 2 * (R - 1) + 1;
    localparam int SW  = R * CRD_W + 1;
    localparam int AW  = $clog2(2 * R) + 1;

    t_crd r_in_dim  [R];
    t_crd r_out_dim [R];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < R; i++) begin
                r_in_dim[i]  <= t_crd'(1);
                r_out_dim[i] <= t_crd'(1);
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < R; i++) begin
                if (i_cfg_index == AW'(i)) begin
                    r_in_dim[i] <= i_cfg_data;
                end
                if (i_cfg_index == AW'(R + i)) begin
                    r_out_dim[i] <= i_cfg_data;
                end
            end
        end
    end
    assign o_cfg_ready = 1'b1;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    t_crd in_crd [4];
    assign in_crd[0] = i_in_coord_0;
    assign in_crd[1] = i_in_coord_1;
    assign in_crd[2] = i_in_coord_2;
    assign in_crd[3] = i_in_coord_3;

    // flatten pipeline
    logic r_val  [NS];
    logic r_last [NS];
    t_crd r_crd  [NS][R];
    t_idx r_idx  [NS];
    t_idx r_lo   [NS];
    t_crd r_hi   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else if (en) begin
            r_val[0] <= i_in_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last[0] <= i_is_last;
            for (int i = 0; i < R; i++) begin
                r_crd[0][i] <= (i < 4) ? in_crd[i % 4] : '0;
            end
            r_idx[0] <= {{(IDX_W-CRD_W){1'b0}}, in_crd[0]};
        end
    end

    for (genvar i = 1; i < R; i++) begin : g_fl
        localparam int SA = 2 * i - 1;
        localparam int SB = 2 * i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[SA] <= 1'b0;
                r_val[SB] <= 1'b0;
            end else if (en) begin
                r_val[SA] <= r_val[SA-1];
                r_val[SB] <= r_val[SA];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_last[SA] <= r_last[SA-1];
                r_crd[SA]  <= r_crd[SA-1];
                r_lo[SA]   <= t_idx'(r_idx[SA-1][CRD_W-1:0]) * t_idx'(r_in_dim[i]);
                r_hi[SA]   <= t_crd'(r_idx[SA-1][IDX_W-1:CRD_W] * r_in_dim[i]);
                r_last[SB] <= r_last[SA];
                r_crd[SB]  <= r_crd[SA];
                r_idx[SB]  <= r_lo[SA] + {r_hi[SA], {CRD_W{1'b0}}}
                            + {{(IDX_W-CRD_W){1'b0}}, r_crd[SA][i]};
            end
        end
    end

    // split pipeline, fastest output dimension first
    logic          w_val  [R+1];
    t_idx          w_idx  [R+1];
    logic [SW-1:0] w_side [R+1];

    assign w_val[0]  = r_val[NS-1];
    assign w_idx[0]  = r_idx[NS-1];
    assign w_side[0] = {r_last[NS-1], {(R*CRD_W){1'b0}}};

    for (genvar k = 0; k < R; k++) begin : g_dv
        localparam int DI = R - 1 - k;
        t_crd          d_rem;
        logic [SW-1:0] d_side;
        sir_divmod #(.SW(SW)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_valid    (w_val[k]),
            .i_dividend (w_idx[k]),
            .i_divisor  ({r_out_dim[DI] == '0, r_out_dim[DI]}),
            .i_side     (w_side[k]),
            .o_valid    (w_val[k+1]),
            .o_quot     (w_idx[k+1]),
            .o_rem      (d_rem),
            .o_side     (d_side)
        );
        assign w_side[k+1] = d_side | (SW'(d_rem) << (DI * CRD_W));
    end

    t_crd oc [R];
    for (genvar i = 0; i < R; i++) begin : g_oc
        assign oc[i] = w_side[R][i*CRD_W +: CRD_W];
    end

    assign o_out_valid   = w_val[R];
    assign o_last_out    = w_side[R][SW-1];
    assign o_out_coord_0 = oc[0];
    assign o_out_coord_1 = (R > 1) ? oc[1 % R] : '0;
    assign o_out_coord_2 = (R > 2) ? oc[2 % R] : '0;
    assign o_out_coord_3 = (R > 3) ? oc[3 % R] : '0;
endmodule

### rtl/sir_checker.sv
// Port-level checker for the sparse index reshape block, bound to the top level.
module sir_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_cfg_ready,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sir_pkg::t_crd o_out_coord_0,
    input logic          o_last_out
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_coord_0) && $stable(o_last_out))
        else $error("result changed while stalled");
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item accepted while pipeline stalled");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");
endmodule

bind sparse_index_reshape sir_checker u_sir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_coord_0 (o_out_coord_0),
    .o_last_out    (o_last_out)
);

### tb/tb_sparse_index_reshape.sv
// Self-checking testbench for the sparse index reshape block: extreme cases, random shapes and coordinates.
module tb_sparse_index_reshape;
    timeunit 1ns;
    timeprecision 1ps;
    import sir_pkg::*;

    localparam int RANK = MAX_RANK_DEF;
    localparam int LATENCY = 1 + 2*(RANK-1) + 64*RANK;
    localparam int CFG_IN_DIM_0 = 0;
    localparam int CFG_OUT_DIM_0 = RANK;

    typedef struct packed {
        t_crd c0, c1, c2, c3;
        logic last;
    } t_tuple;

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        $display("MISMATCH %s: got %h exp %h at %0t", what, got, exp_v, $realtime);
        errors++;
    endtask

    class reshape_scoreboard;
        t_crd in_dim[RANK];
        t_crd out_dim[RANK];
        t_tuple pending[$];
        int checked;

        function new();
            for (int i = 0; i < RANK; i++) begin
                in_dim[i] = 1;
                out_dim[i] = 1;
            end
            checked = 0;
        endfunction

        function void set_reg(int idx, t_crd v);
            if (idx < RANK) in_dim[idx] = v;
            else if (idx < 2*RANK) out_dim[idx-RANK] = v;
        endfunction

        function void note_input(t_tuple t);
            logic [63:0] lin;
            logic [63:0] sz;
            t_crd crd[RANK];
            t_tuple r;
            crd[0] = t.c0; crd[1] = t.c1; crd[2] = t.c2; crd[3] = t.c3;
            lin = 0;
            for (int i = 0; i < RANK; i++) lin = lin * {32'd0, in_dim[i]} + {32'd0, crd[i]};
            for (int i = RANK-1; i >= 0; i--) begin
                sz = (out_dim[i] == 0) ? 64'h1_0000_0000 : {32'd0, out_dim[i]};
                crd[i] = t_crd'(lin % sz);
                lin = lin / sz;
            end
            r.c0 = crd[0]; r.c1 = crd[1]; r.c2 = crd[2]; r.c3 = crd[3];
            r.last = t.last;
            pending.push_back(r);
        endfunction

        task check_result(t_tuple got);
            t_tuple e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.c0 !== e.c0) report_mismatch("out_coord_0", got.c0, e.c0);
            if (got.c1 !== e.c1) report_mismatch("out_coord_1", got.c1, e.c1);
            if (got.c2 !== e.c2) report_mismatch("out_coord_2", got.c2, e.c2);
            if (got.c3 !== e.c3) report_mismatch("out_coord_3", got.c3, e.c3);
            if (got.last !== e.last) report_mismatch("last_out", got.last, e.last);
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [$clog2(2*RANK):0] cfg_index = 0;
    t_crd cfg_data = 0;
    logic in_valid = 0, in_ready;
    t_crd ic0 = 0, ic1 = 0, ic2 = 0, ic3 = 0;
    logic is_last = 0;
    logic out_valid, out_ready = 0;
    t_crd oc0, oc1, oc2, oc3;
    logic last_out;

    reshape_scoreboard sb = new();
    bit no_idle = 0;
    int hold_off = 0;
    int sent = 0;

    always #10 clk = ~clk;

    sparse_index_reshape u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_coord_0(ic0), .i_in_coord_1(ic1), .i_in_coord_2(ic2), .i_in_coord_3(ic3),
        .i_is_last(is_last),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_coord_0(oc0), .o_out_coord_1(oc1), .o_out_coord_2(oc2),
        .o_out_coord_3(oc3), .o_last_out(last_out)
    );

    // result side: sample at rising edge, drive ready at falling edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{oc0, oc1, oc2, oc3, last_out});
    end

    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off--;
            out_ready <= 0;
        end else if (no_idle || $urandom_range(0, 3) != 0) begin
            out_ready <= 1;
        end else begin
            out_ready <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    end

    task automatic write_reg(input int idx, input t_crd v);
        cfg_valid <= 1;
        cfg_index <= idx[$bits(cfg_index)-1:0];
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic t_crd rand_dim(int mode);
        case (mode)
            0: return 1;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            3: return $urandom_range(1, 16);
            4: return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_crd rand_crd(t_crd dim);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'hFFFF_FFFE;
            2: return $urandom_range(0, 32'hFFFF_FFFE);
            default: return (dim == 0) ? $urandom_range(0, 32'hFFFF_FFFE)
                                       : $urandom_range(0, dim - 1);
        endcase
    endfunction

    // leaves valid high if another item follows immediately
    task automatic send_item(input t_tuple t, input bit gaps);
        in_valid <= 1;
        ic0 <= t.c0; ic1 <= t.c1; ic2 <= t.c2; ic3 <= t.c3;
        is_last <= t.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(t);
        sent++;
        @(negedge clk);
        if (gaps && !no_idle && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic random_shape(int mode_max);
        for (int i = 0; i < 2*RANK; i++) write_reg(i, rand_dim($urandom_range(0, mode_max)));
    endtask

    task automatic random_items(int n);
        t_tuple t;
        for (int k = 0; k < n; k++) begin
            t.c0 = rand_crd(sb.in_dim[0]);
            t.c1 = rand_crd(sb.in_dim[1]);
            t.c2 = rand_crd(sb.in_dim[2]);
            t.c3 = rand_crd(sb.in_dim[3]);
            t.last = $urandom_range(0, 1);
            send_item(t, 1);
        end
        in_valid <= 0;
    endtask

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // reset shape, then extremes
        send_item('{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1}, 0);
        send_item('{0, 0, 0, 0, 1'b0}, 0);
        in_valid <= 0;
        drain();
        for (int i = 0; i < RANK; i++) write_reg(CFG_IN_DIM_0 + i, 32'hFFFF_FFFF);
        for (int i = 0; i < RANK; i++) write_reg(CFG_OUT_DIM_0 + i, 0);
        send_item('{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1}, 0);
        send_item('{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321, 1'b0}, 0);
        in_valid <= 0;
        drain();
        write_reg(CFG_IN_DIM_0 + 1, 0);
        write_reg(CFG_OUT_DIM_0 + 3, 7);
        write_reg(CFG_OUT_DIM_0 + 2, 32'hFFFF_FFFF);
        send_item('{3, 9, 32'hFFFF_FFFE, 5, 1'b1}, 0);
        send_item('{32'hFFFF_FFFE, 1, 2, 3, 1'b0}, 0);
        in_valid <= 0;
        drain();
        // 2x3x4 -> 4x6: small well-formed shapes
        write_reg(CFG_IN_DIM_0, 1); write_reg(CFG_IN_DIM_0 + 1, 2);
        write_reg(CFG_IN_DIM_0 + 2, 3); write_reg(CFG_IN_DIM_0 + 3, 4);
        write_reg(CFG_OUT_DIM_0, 1); write_reg(CFG_OUT_DIM_0 + 1, 1);
        write_reg(CFG_OUT_DIM_0 + 2, 4); write_reg(CFG_OUT_DIM_0 + 3, 6);
        write_reg(2*RANK, 32'hDEAD_BEEF); // index past the list, ignored
        write_reg(2*RANK + 3, 0);
        random_items(12);
        drain();

        // backpressure: receiver stalls long while sender keeps offering items with random gaps
        hold_off = LATENCY * 2;
        random_items(LATENCY + 40);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_shape(ph < 4 ? 4 : 5);
            random_items(104);
            drain();
        end

        no_idle = 1;
        random_shape(5);
        random_items(200);
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        $display("Sent %0d items, checked %0d results over 13 shape settings.", sent, sb.checked);
        if (errors == 0 && sb.pending.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
